// File: design/tgarle_pkg.sv
// ---------------------------------------------------------------------------
// tgarle_pkg
// Shared types and constants for the TGA run-length pixel decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package tgarle_pkg;

  localparam int MAX_BYTES_PER_PIXEL = 4;

  // Packet header: bit 7 marks a repeat packet, low 7 bits hold count - 1
  localparam int HDR_REPEAT_BIT = 7;
  localparam logic [6:0] HDR_COUNT_MASK = 7'd127;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;
  localparam logic [CFG_IDX_W-1:0] CFG_BPP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RLE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 2'd2;

  typedef struct packed {
    logic [2:0]  bytes_per_pixel;
    logic        rle_enable;
    logic [30:0] total_pixels;
  } cfg_t;

  typedef struct packed {
    logic        expect_header;
    logic        repeat_packet;
    logic [7:0]  packet_left;
    logic [1:0]  byte_index;
    logic [30:0] pixels_done;
  } dec_state_t;

  typedef struct packed {
    logic [7:0] chan0;
    logic [7:0] chan1;
    logic [7:0] chan2;
    logic [7:0] chan3;
    logic [7:0] run_length;
    logic       image_done;
  } pixel_t;

  typedef struct packed {
    dec_state_t state_next;
    logic       byte_we;
    logic [1:0] byte_addr;
    logic       res_valid;
    pixel_t     res;
  } dec_out_t;

endpackage

`default_nettype wire

// File: design/tgarle_if.sv
// ---------------------------------------------------------------------------
// tgarle_if
// Valid/ready channels for stream bytes in and decoded pixels out.
// ---------------------------------------------------------------------------
`default_nettype none

interface tgarle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       image_start;

  modport source(output valid, output in_byte, output image_start, input ready);
  modport sink(input valid, input in_byte, input image_start, output ready);
endinterface

interface tgarle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] chan0;
  logic [7:0] chan1;
  logic [7:0] chan2;
  logic [7:0] chan3;
  logic [7:0] run_length;
  logic       image_done;

  modport source(output valid, output chan0, output chan1, output chan2,
                 output chan3, output run_length, output image_done,
                 input ready);
  modport sink(input valid, input chan0, input chan1, input chan2,
               input chan3, input run_length, input image_done,
               output ready);
endinterface

`default_nettype wire

// File: design/tgarle_decode.sv
// ---------------------------------------------------------------------------
// tgarle_decode
// Next-state and result logic for one stream byte.
// ---------------------------------------------------------------------------
`default_nettype none

module tgarle_decode
  import tgarle_pkg::*;
(
  input  var cfg_t            cfg,
  input  var dec_state_t      state,
  input  wire [3:0][7:0]      pixel_bytes,
  input  wire [7:0]           in_byte,
  input  wire                 image_start,
  output var dec_out_t        dout
);

  logic [2:0]      bpp;
  dec_state_t      st;
  logic [31:0]     diff;
  logic            complete;
  logic [30:0]     room;
  logic [3:0][7:0] pix;
  logic [7:0]      inc;
  logic [30:0]     sum;
  logic            clip;
  logic [7:0]      run;
  logic [7:0]      left_dec;

  always_comb begin
    // Out-of-range widths clamp to 1 .. MAX_BYTES_PER_PIXEL
    if (cfg.bytes_per_pixel == 3'd0) begin
      bpp = 3'd1;
    end else if (cfg.bytes_per_pixel > 3'(MAX_BYTES_PER_PIXEL)) begin
      bpp = 3'(MAX_BYTES_PER_PIXEL);
    end else begin
      bpp = cfg.bytes_per_pixel;
    end

    st = state;
    if (image_start) begin
      st.expect_header = 1'b1;
      st.repeat_packet = 1'b0;
      st.packet_left   = 8'd0;
      st.byte_index    = 2'd0;
      st.pixels_done   = 31'd0;
    end

    // One subtract gives both the space left and the done flag
    diff     = {1'b0, cfg.total_pixels} - {1'b0, st.pixels_done};
    complete = diff[31] || (diff == 32'd0);
    room     = diff[30:0];

    pix                = pixel_bytes;
    pix[st.byte_index] = in_byte;

    clip = (room[30:8] == 23'd0) && (room[7:0] < st.packet_left);
    inc  = (cfg.rle_enable && st.repeat_packet) ? st.packet_left : 8'd1;
    sum  = st.pixels_done + {23'd0, inc};
    left_dec = (st.packet_left != 8'd0) ? st.packet_left - 8'd1 : 8'd0;

    dout.state_next = st;
    dout.byte_we    = 1'b0;
    dout.byte_addr  = st.byte_index;
    dout.res_valid  = 1'b0;
    run             = 8'd1;

    if (!complete) begin
      if (cfg.rle_enable && st.expect_header) begin
        dout.state_next.packet_left   = {1'b0, in_byte[6:0] & HDR_COUNT_MASK} + 8'd1;
        dout.state_next.repeat_packet = in_byte[HDR_REPEAT_BIT];
        dout.state_next.expect_header = 1'b0;
        dout.state_next.byte_index    = 2'd0;
      end else begin
        dout.byte_we = 1'b1;
        if (({1'b0, st.byte_index} + 3'd1) < bpp) begin
          dout.state_next.byte_index = st.byte_index + 2'd1;
        end else begin
          dout.state_next.byte_index  = 2'd0;
          dout.res_valid              = 1'b1;
          dout.state_next.pixels_done = sum;
          if (cfg.rle_enable) begin
            if (st.repeat_packet) begin
              run                           = clip ? room[7:0] : st.packet_left;
              dout.state_next.packet_left   = 8'd0;
              dout.state_next.expect_header = 1'b1;
              if (clip) begin
                dout.state_next.pixels_done = cfg.total_pixels;
              end
            end else begin
              dout.state_next.packet_left = left_dec;
              if (left_dec == 8'd0) begin
                dout.state_next.expect_header = 1'b1;
              end
            end
          end
        end
      end
    end

    // BGR(A) to RGB(A); narrow pixels pass straight through
    dout.res.chan0 = 8'd0;
    dout.res.chan1 = 8'd0;
    dout.res.chan2 = 8'd0;
    dout.res.chan3 = 8'd0;
    if (bpp >= 3'd3) begin
      dout.res.chan0 = pix[2];
      dout.res.chan1 = pix[1];
      dout.res.chan2 = pix[0];
      if (bpp == 3'd4) begin
        dout.res.chan3 = pix[3];
      end
    end else begin
      dout.res.chan0 = pix[0];
      if (bpp == 3'd2) begin
        dout.res.chan1 = pix[1];
      end
    end
    dout.res.run_length = run;
    dout.res.image_done = ({23'd0, run} == room);
  end

endmodule

`default_nettype wire

// File: design/tga_rle_pixel_decoder.sv
// ---------------------------------------------------------------------------
// tga_rle_pixel_decoder
// TGA image-data decoder: bytes in, RGB(A) or grey pixels out, RLE optional.
// ---------------------------------------------------------------------------
// Throughput: one byte per clock, sustained, while the pixel side keeps up.
// Latency: a pixel completed by an accepted byte is valid on the next cycle.
// The single output register decouples the sides: a byte is taken whenever
// that register is empty or being drained in the same cycle.
// Reset: config returns to 4 bytes/pixel, RLE off, 1 pixel total; the
// decode state expects a header and the output register is emptied.
`default_nettype none

module tga_rle_pixel_decoder
  import tgarle_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   cfg_we,
  input  wire [CFG_IDX_W-1:0]   cfg_index,
  input  wire [CFG_DATA_W-1:0]  cfg_data,
  tgarle_in_if.sink             in_bytes,
  tgarle_out_if.source          pixels
);

  cfg_t            cfg;
  dec_state_t      state;
  logic [3:0][7:0] pixel_bytes;   // no reset: read only after being written
  dec_out_t        dout;
  pixel_t          out_reg;
  logic            out_valid;
  logic            in_acc;

  // Config registers, to be written only while the decoder is idle; the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bytes_per_pixel <= 3'd4;
      cfg.rle_enable      <= 1'b0;
      cfg.total_pixels    <= 31'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BPP:   cfg.bytes_per_pixel <= cfg_data[2:0];
        CFG_RLE:   cfg.rle_enable      <= cfg_data[0];
        CFG_TOTAL: cfg.total_pixels    <= cfg_data[30:0];
        default:   ;
      endcase
    end
  end

  // Byte is taken when the output slot is free or emptying this cycle
  assign in_bytes.ready = !out_valid || pixels.ready;
  assign in_acc         = in_bytes.valid && in_bytes.ready;

  tgarle_decode u_decode (
    .cfg         (cfg),
    .state       (state),
    .pixel_bytes (pixel_bytes),
    .in_byte     (in_bytes.in_byte),
    .image_start (in_bytes.image_start),
    .dout        (dout)
  );

  // Decode state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.expect_header <= 1'b1;
      state.repeat_packet <= 1'b0;
      state.packet_left   <= 8'd0;
      state.byte_index    <= 2'd0;
      state.pixels_done   <= 31'd0;
    end else if (in_acc) begin
      state <= dout.state_next;
    end
  end

  // Assembly of the current pixel's bytes
  always_ff @(posedge clk) begin
    if (in_acc && dout.byte_we) begin
      pixel_bytes[dout.byte_addr] <= in_bytes.in_byte;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc) begin
      out_valid <= dout.res_valid;
    end else if (pixels.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && dout.res_valid) begin
      out_reg <= dout.res;
    end
  end

  assign pixels.valid      = out_valid;
  assign pixels.chan0      = out_reg.chan0;
  assign pixels.chan1      = out_reg.chan1;
  assign pixels.chan2      = out_reg.chan2;
  assign pixels.chan3      = out_reg.chan3;
  assign pixels.run_length = out_reg.run_length;
  assign pixels.image_done = out_reg.image_done;

  // Output slot is empty straight after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !pixels.valid)
    else $error("pixel output valid straight after reset");

  // A completed pixel shows up on the next cycle
  a_pixel_follows: assert property (@(posedge clk) disable iff (rst)
    (in_acc && dout.res_valid) |=> pixels.valid)
    else $error("completed pixel not presented");

  // Run length always within a packet's count
  a_run_range: assert property (@(posedge clk) disable iff (rst)
    pixels.valid |-> (pixels.run_length != 8'd0 && pixels.run_length <= 8'd128))
    else $error("run length out of range");

  // Output payload only changes when a byte is taken
  a_hold_payload: assert property (@(posedge clk) disable iff (rst)
    (!$past(in_acc) && $past(pixels.valid)) |-> $stable(pixels.run_length))
    else $error("pixel changed without a new byte");

endmodule

`default_nettype wire

// File: tb/tb_tga_rle_pixel_decoder.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_tga_rle_pixel_decoder
// Self-checking bench for the TGA run-length pixel decoder. A behavioural
// decoder inside the bench predicts every pixel from the bytes the block
// accepts; a checker matches each pixel leaving the block against the
// oldest prediction. Directed images come first, then random RLE and plain
// streams under random source gaps and sink stalls.
// ---------------------------------------------------------------------------
module tb_tga_rle_pixel_decoder;
  import tgarle_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tgarle_in_if  in_bytes ();
  tgarle_out_if pixels ();

  tga_rle_pixel_decoder uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_bytes  (in_bytes),
    .pixels    (pixels)
  );

  localparam logic [30:0] MAX_TOTAL = 31'd1073741824;

  // Register copy, as last written
  logic [2:0]  fmt_bpp   = 3'd4;
  logic        fmt_rle   = 1'b0;
  logic [30:0] fmt_total = 31'd1;

  // Decode state of the bench's own decoder
  logic        want_header = 1'b1;
  logic        repeat_pkt  = 1'b0;
  logic [7:0]  pkt_left    = 8'd0;
  logic [1:0]  byte_idx    = 2'd0;
  logic [7:0]  pix_bytes [4];
  logic [30:0] done_cnt    = 31'd0;

  pixel_t pending_pixels [$];   // predicted pixels not yet seen at the output
  int     error_count = 0;
  int     bytes_used  = 0;      // bytes that were not dropped by the decoder
  int     burst_left  = 0;
  bit     gaps_on     = 1'b1;
  int     hold_cycles = 0;      // set by a test, counted down by the sink

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Decodes one accepted byte; returns 1 with the pixel it completes.
  function automatic bit decode_byte(input logic [7:0] b, input logic st,
                                     output pixel_t px);
    int          bpp;
    logic [30:0] room;
    logic [30:0] run;
    bpp = (fmt_bpp == 3'd0) ? 1 :
          (int'(fmt_bpp) > MAX_BYTES_PER_PIXEL) ? MAX_BYTES_PER_PIXEL : int'(fmt_bpp);
    px = '0;
    if (st) begin
      want_header = 1'b1;
      repeat_pkt  = 1'b0;
      pkt_left    = 8'd0;
      byte_idx    = 2'd0;
      done_cnt    = 31'd0;
    end
    // image complete (or zero total): byte dropped
    if (done_cnt >= fmt_total) return 1'b0;
    bytes_used++;
    if (fmt_rle && want_header) begin
      pkt_left    = {1'b0, b[6:0] & HDR_COUNT_MASK} + 8'd1;
      repeat_pkt  = b[HDR_REPEAT_BIT];
      want_header = 1'b0;
      byte_idx    = 2'd0;
      return 1'b0;
    end
    pix_bytes[byte_idx] = b;
    if (int'(byte_idx) + 1 < bpp) begin
      byte_idx = byte_idx + 2'd1;
      return 1'b0;
    end
    byte_idx = 2'd0;
    run = 31'd1;
    if (fmt_rle && repeat_pkt) begin
      // one item for the whole run, clipped at the end of the image
      room = fmt_total - done_cnt;
      run  = ({23'd0, pkt_left} > room) ? room : {23'd0, pkt_left};
      pkt_left    = 8'd0;
      want_header = 1'b1;
    end else if (fmt_rle) begin
      if (pkt_left != 8'd0) pkt_left = pkt_left - 8'd1;
      if (pkt_left == 8'd0) want_header = 1'b1;
    end
    // BGR(A) is swapped to RGB(A); grey formats pass straight through
    if (bpp >= 3) begin
      px.chan0 = pix_bytes[2];
      px.chan1 = pix_bytes[1];
      px.chan2 = pix_bytes[0];
      if (bpp == 4) px.chan3 = pix_bytes[3];
    end else begin
      px.chan0 = pix_bytes[0];
      if (bpp == 2) px.chan1 = pix_bytes[1];
    end
    done_cnt = done_cnt + run;
    px.run_length = run[7:0];
    px.image_done = (done_cnt == fmt_total);
    return 1'b1;
  endfunction

  // Offers one byte and waits for it to be taken. Valid stays high after
  // acceptance; it only drops at the start of a gap or in wait_idle.
  task automatic send_byte(input logic [7:0] b, input logic st);
    pixel_t px;
    if (gaps_on && burst_left == 0) begin
      in_bytes.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    if (burst_left > 0) burst_left--;
    in_bytes.valid       <= 1'b1;
    in_bytes.in_byte     <= b;
    in_bytes.image_start <= st;
    do @(posedge clk); while (!in_bytes.ready);
    if (decode_byte(b, st, px)) pending_pixels.push_back(px);
  endtask

  // Source goes quiet until every predicted pixel has come out, then waits
  // on for the output register to settle.
  task automatic wait_idle();
    in_bytes.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all three registers back to back, only once the block is idle
  task automatic set_format(input logic [2:0] bpp, input logic rle,
                            input logic [30:0] total);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BPP;
    cfg_data  <= {28'd0, bpp};
    @(posedge clk);
    cfg_index <= CFG_RLE;
    cfg_data  <= {30'd0, rle};
    @(posedge clk);
    cfg_index <= CFG_TOTAL;
    cfg_data  <= total;
    @(posedge clk);
    cfg_we    <= 1'b0;
    fmt_bpp   = bpp;
    fmt_rle   = rle;
    fmt_total = total;
  endtask

  // Sink: segments of random length, each with its own readiness; a run
  // of random stalls is capped unless a test asked for a hold-off.
  initial begin : pixel_sink
    int seg_left;
    int stall_run;
    int ready_odds;
    bit go;
    seg_left   = 0;
    stall_run  = 0;
    ready_odds = 8;
    pixels.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (seg_left == 0) begin
        seg_left = $urandom_range(5, 60);
        case ($urandom_range(0, 3))
          0: ready_odds = 8;
          1: ready_odds = 6;
          2: ready_odds = 4;
          default: ready_odds = 1;
        endcase
      end
      seg_left--;
      if (hold_cycles > 0) begin
        hold_cycles--;
        pixels.ready <= 1'b0;
      end else begin
        go = (stall_run >= 12) || ($urandom_range(0, 7) < ready_odds);
        pixels.ready <= go;
        stall_run = go ? 0 : stall_run + 1;
      end
    end
  end

  // Matches every pixel leaving the block against the oldest prediction
  initial begin : pixel_checker
    pixel_t got;
    pixel_t want;
    forever begin
      @(posedge clk);
      if (!rst && pixels.valid && pixels.ready) begin
        got = {pixels.chan0, pixels.chan1, pixels.chan2, pixels.chan3,
               pixels.run_length, pixels.image_done};
        if (pending_pixels.size() == 0) begin
          if (error_count < 10)
            $display("%0t: pixel with none predicted:", $time,
                     " c0=%h c1=%h c2=%h c3=%h run=%0d done=%b",
                     got.chan0, got.chan1, got.chan2, got.chan3,
                     got.run_length, got.image_done);
          error_count++;
        end else begin
          want = pending_pixels.pop_front();
          if (got !== want) begin
            if (error_count < 10)
              $display("%0t: pixel mismatch:", $time,
                       " exp c0=%h c1=%h c2=%h c3=%h run=%0d done=%b,",
                       want.chan0, want.chan1, want.chan2, want.chan3,
                       want.run_length, want.image_done,
                       " got c0=%h c1=%h c2=%h c3=%h run=%0d done=%b",
                       got.chan0, got.chan1, got.chan2, got.chan3,
                       got.run_length, got.image_done);
            error_count++;
          end
        end
      end
    end
  end

  // Plain pixels in every format. The first image runs at the power-on
  // format (BGRA, one pixel), which also fills all four byte slots.
  task automatic test_plain_pixels();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h11, 1'b0);   // image complete: dropped
    set_format(3'd1, 1'b0, 31'd2);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    set_format(3'd2, 1'b0, 31'd4);
    send_byte(8'h80, 1'b1);
    send_byte(8'h7F, 1'b0);
    set_format(3'd3, 1'b0, 31'd4);
    send_byte(8'h01, 1'b1);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    // zero bytes per pixel decodes as one
    set_format(3'd0, 1'b0, 31'd4);
    send_byte(8'hC3, 1'b1);
  endtask

  // Raw packet, short repeat, then a full-count repeat clipped at image end
  task automatic test_rle_packets();
    set_format(3'd1, 1'b1, 31'd5);
    send_byte(8'h01, 1'b1);
    send_byte(8'hAA, 1'b0);
    send_byte(8'hBB, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hCC, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hDD, 1'b0);
    send_byte(8'hEE, 1'b0);   // past the end: dropped
  endtask

  // Zero pixel total: image complete from the start, nothing comes out
  task automatic test_zero_total();
    set_format(3'd1, 1'b0, 31'd0);
    send_byte(8'h42, 1'b1);
  endtask

  // RLE toggled in the middle of a raw packet; the packet resumes after
  task automatic test_mid_image_config();
    set_format(3'd1, 1'b1, MAX_TOTAL);
    send_byte(8'h01, 1'b1);
    send_byte(8'h10, 1'b0);
    set_format(3'd1, 1'b0, MAX_TOTAL);
    send_byte(8'h30, 1'b0);
    set_format(3'd1, 1'b1, MAX_TOTAL);
    send_byte(8'h40, 1'b0);
  endtask

  // Long sink hold-off while the source streams back to back, so the
  // block fills and stalls its input; then the source waits for a drain.
  task automatic test_backpressure();
    set_format(3'd1, 1'b0, 31'd1000);
    gaps_on     = 1'b0;
    hold_cycles = 60;
    send_byte(8'h00, 1'b1);
    repeat (39) send_byte(8'($urandom), 1'b0);
    wait_idle();
    repeat (10) send_byte(8'($urandom), 1'b0);
    gaps_on = 1'b1;
  endtask

  // One image's worth of bytes, shaped by the decoder's own state so that
  // headers land where a header is due; the odd stray byte, a rare restart
  // and a few trailing bytes after the image give the noise.
  task automatic stream_image(input bit fresh);
    int         budget;
    bit         st;
    logic [7:0] b;
    budget = $urandom_range(20, 200);
    st     = fresh;
    while (st || (budget > 0 && done_cnt < fmt_total)) begin
      if ($urandom_range(0, 63) == 0) begin
        b = 8'($urandom);
      end else if (fmt_rle && (st || want_header)) begin
        b[HDR_REPEAT_BIT] = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 5))
          0: b[6:0] = HDR_COUNT_MASK;
          1: b[6:0] = 7'd0;
          default: b[6:0] = 7'($urandom_range(1, 6));
        endcase
      end else begin
        case ($urandom_range(0, 7))
          0: b = 8'h00;
          1: b = 8'hFF;
          default: b = 8'($urandom);
        endcase
      end
      send_byte(b, st);
      budget--;
      st = ($urandom_range(0, 99) == 0);
    end
    repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'b0);
  endtask

  // Random formats, mostly in range, with the extremes of the pixel total
  task automatic test_random_stream();
    int          goal;
    logic [2:0]  bpp;
    logic        rle;
    logic [30:0] total;
    goal = bytes_used + 800;
    while (bytes_used < goal) begin
      bpp = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
                                        : 3'($urandom_range(1, 4));
      rle = ($urandom_range(0, 2) != 0);
      case ($urandom_range(0, 11))
        0: total = 31'd1;
        1: total = MAX_TOTAL;
        2: total = 31'd0;
        default: total = 31'($urandom_range(1, 40));
      endcase
      set_format(bpp, rle, total);
      gaps_on = ($urandom_range(0, 3) != 0);
      // a phase may carry on the old image under the new format
      repeat ($urandom_range(1, 3)) stream_image($urandom_range(0, 9) != 0);
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_index            <= CFG_BPP;
    cfg_data             <= '0;
    in_bytes.valid       <= 1'b0;
    in_bytes.in_byte     <= 8'h00;
    in_bytes.image_start <= 1'b0;
    for (int i = 0; i < 4; i++) pix_bytes[i] = 8'h00;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_plain_pixels();
    test_rle_packets();
    test_zero_total();
    test_mid_image_config();
    test_backpressure();
    test_random_stream();

    wait_idle();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: filelist.f
design/tgarle_pkg.sv
design/tgarle_if.sv
design/tgarle_decode.sv
design/tga_rle_pixel_decoder.sv
tb/tb_tga_rle_pixel_decoder.sv
